// ===== design/rstmgr_pkg.sv =====
package rstmgr_pkg;

  // Request commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  // Access error codes
  localparam logic [2:0] ERR_OK   = 3'd0;
  localparam logic [2:0] ERR_BAD  = 3'd1;
  localparam logic [2:0] ERR_RO   = 3'd2;
  localparam logic [2:0] ERR_WO   = 3'd3;
  localparam logic [2:0] ERR_LOCK = 3'd4;

  // Register map (word index)
  localparam logic [4:0] REG_ALERT_TEST       = 5'd0;
  localparam logic [4:0] REG_SWRST_REQ        = 5'd1;
  localparam logic [4:0] REG_RESET_INFO       = 5'd2;
  localparam logic [4:0] REG_ALERT_REGWEN     = 5'd3;
  localparam logic [4:0] REG_ALERT_INFO_CTRL  = 5'd4;
  localparam logic [4:0] REG_ALERT_INFO_ATTR  = 5'd5;
  localparam logic [4:0] REG_ALERT_INFO       = 5'd6;
  localparam logic [4:0] REG_CPU_REGWEN       = 5'd7;
  localparam logic [4:0] REG_CPU_INFO_CTRL    = 5'd8;
  localparam logic [4:0] REG_CPU_INFO_ATTR    = 5'd9;
  localparam logic [4:0] REG_CPU_INFO         = 5'd10;
  localparam logic [4:0] REG_SW_RST_REGWEN_LO = 5'd11;
  localparam logic [4:0] REG_SW_RST_REGWEN_HI = 5'd18;
  localparam logic [4:0] REG_SW_RST_CTRL_LO   = 5'd19;
  localparam logic [4:0] REG_SW_RST_CTRL_HI   = 5'd26;
  localparam logic [4:0] REG_ERR_CODE         = 5'd27;

  // Multi-bit boolean codes for the software reset request register
  localparam logic [3:0] MB4_TRUE  = 4'h6;
  localparam logic [3:0] MB4_FALSE = 4'h9;

  localparam logic [7:0] INFO_CTRL_MASK = 8'hf1;
  localparam logic [7:0] CAUSE_POR      = 8'h01;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [2:0]  reset_reason;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  access_error;
    logic        sw_rst_request;
    logic [1:0]  alert_levels;
    logic [7:0]  device_reset_n;
    logic        shutdown;
  } rsp_t;

endpackage

// ===== design/rstmgr_regfile.sv =====
module rstmgr_regfile #(
  parameter int NUM_DEVICE_RESETS = 8,
  parameter int NUM_ALERTS        = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  rstmgr_pkg::req_t    req,
  input  logic                cfg_write_en,
  input  logic [7:0]          cfg_write_data,
  output rstmgr_pkg::rsp_t    rsp
);
  import rstmgr_pkg::*;

  localparam int DEV_BITS = (NUM_DEVICE_RESETS > 8) ? 8 : NUM_DEVICE_RESETS;
  localparam int ALERT_BITS = (NUM_ALERTS > 2) ? 2 : NUM_ALERTS;
  localparam logic [7:0] DEV_MASK = 8'((9'd1 << DEV_BITS) - 9'd1);
  localparam logic [1:0] ALERT_MASK = 2'((3'd1 << ALERT_BITS) - 3'd1);
  localparam logic [4:0] NDEV = 5'(NUM_DEVICE_RESETS);

  logic [3:0] swrst_code, swrst_code_next;
  logic [7:0] reset_cause, reset_cause_next;
  logic       alert_lock_open, alert_lock_open_next;
  logic [7:0] alert_info_control, alert_info_control_next;
  logic       cpu_lock_open, cpu_lock_open_next;
  logic [7:0] cpu_info_control, cpu_info_control_next;
  logic [7:0] device_lock_open, device_lock_open_next;
  logic [7:0] device_control_n, device_control_n_next;
  logic [1:0] alert_test_bits, alert_test_bits_next;
  logic       sw_reset_line, sw_reset_line_next;
  logic [7:0] fatal_countdown, fatal_countdown_next;

  logic [2:0]  dev;
  logic        dev_bad;
  logic [31:0] rdata;
  logic [2:0]  err;
  logic        shut;

  // slot index: same low bits for both REGWEN and CTRL ranges
  assign dev     = 3'(req.reg_index - REG_SW_RST_REGWEN_LO);
  assign dev_bad = ({2'b00, dev} >= NDEV);

  always_comb begin
    swrst_code_next         = swrst_code;
    reset_cause_next        = reset_cause;
    alert_lock_open_next    = alert_lock_open;
    alert_info_control_next = alert_info_control;
    cpu_lock_open_next      = cpu_lock_open;
    cpu_info_control_next   = cpu_info_control;
    device_lock_open_next   = device_lock_open;
    device_control_n_next   = device_control_n;
    alert_test_bits_next    = alert_test_bits;
    sw_reset_line_next      = sw_reset_line;
    fatal_countdown_next    = fatal_countdown;
    rdata = '0;
    err   = ERR_OK;
    shut  = 1'b0;

    case (req.cmd)
      CMD_READ: begin
        if (req.reg_index inside {[REG_SW_RST_REGWEN_LO:REG_SW_RST_CTRL_HI]}) begin
          if (dev_bad) begin
            err = ERR_BAD;
          end else if (req.reg_index <= REG_SW_RST_REGWEN_HI) begin
            rdata = {31'b0, device_lock_open[dev]};
          end else begin
            rdata = {31'b0, device_control_n[dev]};
          end
        end else begin
          case (req.reg_index)
            REG_ALERT_TEST:      err   = ERR_WO;
            REG_SWRST_REQ:       rdata = {28'b0, swrst_code};
            REG_RESET_INFO:      rdata = {24'b0, reset_cause};
            REG_ALERT_REGWEN:    rdata = {31'b0, alert_lock_open};
            REG_ALERT_INFO_CTRL: rdata = {24'b0, alert_info_control};
            REG_CPU_REGWEN:      rdata = {31'b0, cpu_lock_open};
            REG_CPU_INFO_CTRL:   rdata = {24'b0, cpu_info_control};
            REG_ALERT_INFO_ATTR, REG_ALERT_INFO, REG_CPU_INFO_ATTR, REG_CPU_INFO,
            REG_ERR_CODE:        rdata = '0;
            default:             err   = ERR_BAD;
          endcase
        end
      end
      CMD_WRITE: begin
        if (req.reg_index inside {[REG_SW_RST_REGWEN_LO:REG_SW_RST_CTRL_HI]}) begin
          if (dev_bad) begin
            err = ERR_BAD;
          end else if (req.reg_index <= REG_SW_RST_REGWEN_HI) begin
            if (!req.write_data[0]) device_lock_open_next[dev] = 1'b0;
          end else if (!device_lock_open[dev]) begin
            err = ERR_LOCK;
          end else begin
            device_control_n_next[dev] = req.write_data[0];
          end
        end else begin
          case (req.reg_index)
            REG_ALERT_TEST: alert_test_bits_next = req.write_data[1:0] & ALERT_MASK;
            REG_SWRST_REQ: begin
              swrst_code_next = req.write_data[3:0];
              if (req.write_data[3:0] == MB4_TRUE) begin
                sw_reset_line_next = 1'b1;
                if (fatal_countdown != 8'd0) begin
                  fatal_countdown_next = fatal_countdown - 8'd1;
                  shut = (fatal_countdown == 8'd1);
                end
              end
            end
            REG_RESET_INFO:   reset_cause_next = reset_cause & ~req.write_data[7:0];
            REG_ALERT_REGWEN: alert_lock_open_next = alert_lock_open & req.write_data[0];
            REG_ALERT_INFO_CTRL: begin
              if (!alert_lock_open) err = ERR_LOCK;
              else alert_info_control_next = req.write_data[7:0] & INFO_CTRL_MASK;
            end
            REG_CPU_REGWEN: cpu_lock_open_next = cpu_lock_open & req.write_data[0];
            REG_CPU_INFO_CTRL: begin
              if (!cpu_lock_open) err = ERR_LOCK;
              else cpu_info_control_next = req.write_data[7:0] & INFO_CTRL_MASK;
            end
            REG_ALERT_INFO_ATTR, REG_ALERT_INFO, REG_CPU_INFO_ATTR, REG_CPU_INFO,
            REG_ERR_CODE: err = ERR_RO;
            default:      err = ERR_BAD;
          endcase
        end
      end
      CMD_EVENT: begin
        // reason zero is a released line: no-op
        if (req.reset_reason != 3'd0) begin
          reset_cause_next        = 8'd1 << req.reset_reason;
          swrst_code_next         = MB4_FALSE;
          alert_test_bits_next    = '0;
          alert_lock_open_next    = 1'b1;
          cpu_lock_open_next      = 1'b1;
          device_lock_open_next   = DEV_MASK;
          device_control_n_next   = DEV_MASK;
          sw_reset_line_next      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.read_data      = rdata;
    rsp.access_error   = err;
    rsp.sw_rst_request = sw_reset_line_next;
    rsp.alert_levels   = alert_test_bits_next;
    rsp.device_reset_n = device_control_n_next;
    rsp.shutdown       = shut;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swrst_code         <= MB4_FALSE;
      reset_cause        <= CAUSE_POR;
      alert_lock_open    <= 1'b1;
      alert_info_control <= '0;
      cpu_lock_open      <= 1'b1;
      cpu_info_control   <= '0;
      device_lock_open   <= DEV_MASK;
      device_control_n   <= DEV_MASK;
      alert_test_bits    <= '0;
      sw_reset_line      <= 1'b0;
      fatal_countdown    <= '0;
    end else if (cfg_write_en) begin
      fatal_countdown <= cfg_write_data;
    end else if (accept) begin
      swrst_code         <= swrst_code_next;
      reset_cause        <= reset_cause_next;
      alert_lock_open    <= alert_lock_open_next;
      alert_info_control <= alert_info_control_next;
      cpu_lock_open      <= cpu_lock_open_next;
      cpu_info_control   <= cpu_info_control_next;
      device_lock_open   <= device_lock_open_next;
      device_control_n   <= device_control_n_next;
      alert_test_bits    <= alert_test_bits_next;
      sw_reset_line      <= sw_reset_line_next;
      fatal_countdown    <= fatal_countdown_next;
    end
  end

  a_event_cause: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_write_en && req.cmd == CMD_EVENT && req.reset_reason != 3'd0
    |=> $onehot(reset_cause) && !sw_reset_line && device_lock_open == DEV_MASK)
    else $error("reset request did not leave one-hot cause and warm state");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_write_en && req.cmd == CMD_WRITE && req.reg_index == REG_SWRST_REQ &&
    req.write_data[3:0] == MB4_TRUE && fatal_countdown != 8'd0
    |=> fatal_countdown == $past(fatal_countdown) - 8'd1 && sw_reset_line)
    else $error("fatal countdown did not step on software reset");

  a_dev_mask: assert property (@(posedge clk) disable iff (rst)
    ((device_control_n | device_lock_open) & ~DEV_MASK) == 8'd0)
    else $error("device bits beyond configured count are set");

endmodule

// ===== design/reset_manager_register_bank.sv =====
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+----------------------------------
// request  | in  | in_valid / in_ready   | in_req  (cmd, index, data, reason)
// response | out | out_valid / out_ready | out_rsp (data, error, status)
// config   | in  | cfg_write_en          | cfg_write_data (fatal limit)
//
// One request per cycle unless out_ready stalls; responses are registered.
// All decode and read-modify-write logic sits between the request port and
// the response register, so the rate is set by that single register stage.
// in_ready is high whenever the response register is empty or being drained.
// Reset (rst, synchronous) acts as power-on: cause = POR, locks open.
// A config write reloads the fatal countdown; issue it only while idle.
module reset_manager_register_bank #(
  parameter int NUM_DEVICE_RESETS = 8,
  parameter int NUM_ALERTS        = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rstmgr_pkg::req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output rstmgr_pkg::rsp_t out_rsp,
  input  logic             cfg_write_en,
  input  logic [7:0]       cfg_write_data
);
  import rstmgr_pkg::*;

  localparam int ALERT_BITS = (NUM_ALERTS > 2) ? 2 : NUM_ALERTS;
  localparam logic [1:0] ALERT_MASK = 2'((3'd1 << ALERT_BITS) - 3'd1);

  logic accept;
  rsp_t rsp_next;

  // response register frees up the same cycle it is drained
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rstmgr_regfile #(
    .NUM_DEVICE_RESETS(NUM_DEVICE_RESETS),
    .NUM_ALERTS       (NUM_ALERTS)
  ) u_regfile (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req           (in_req),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .rsp           (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp <= rsp_next;
    end
  end

  // shutdown only comes from a software reset write, which raises the line
  a_shut_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.shutdown |-> out_rsp.sw_rst_request &&
    out_rsp.access_error == ERR_OK)
    else $error("shutdown pulse without software reset");

  a_rdata_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.read_data != 32'd0 |-> out_rsp.access_error == ERR_OK)
    else $error("nonzero read data with an access error");

  a_alert_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rsp.alert_levels & ~ALERT_MASK) == 2'd0)
    else $error("alert level beyond configured alert count");

endmodule

// ===== tb/reset_manager_register_bank_tb.sv =====
module reset_manager_register_bank_tb;
  import rstmgr_pkg::*;

  localparam int NUM_DEV = 8;
  localparam int NUM_ALR = 2;
  // cmd value the block must treat as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one line of stimulus; typed rows carry a hand-written response
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  req_t       in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rsp_t       out_rsp;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = '0;

  reset_manager_register_bank #(
    .NUM_DEVICE_RESETS(NUM_DEV),
    .NUM_ALERTS(NUM_ALR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the register bank
  // ---------------------------------------------------------------------
  logic [7:0]         fatal_lim;
  logic [7:0]         fatal_cnt;
  logic [3:0]         req_code;
  logic [7:0]         cause_bits;
  logic               alert_wen;
  logic [7:0]         alert_ctrl;
  logic               cpu_wen;
  logic [7:0]         cpu_ctrl;
  logic [7:0]         dev_wen;
  logic [7:0]         dev_rst_n;
  logic [NUM_ALR-1:0] alert_bits;
  logic               swrst_line;

  // warm reset: locks reopen, device controls release, cause/info kept
  function automatic void warm_restart();
    req_code   = MB4_FALSE;
    alert_bits = '0;
    alert_wen  = 1'b1;
    cpu_wen    = 1'b1;
    dev_wen    = 8'((1 << NUM_DEV) - 1);
    dev_rst_n  = 8'((1 << NUM_DEV) - 1);
    swrst_line = 1'b0;
  endfunction

  function automatic void power_on();
    fatal_lim  = '0;
    fatal_cnt  = '0;
    cause_bits = CAUSE_POR;
    alert_ctrl = '0;
    cpu_ctrl   = '0;
    warm_restart();
  endfunction

  // Applies one request to the shadow bank and returns its response.
  function automatic rsp_t model_access(input req_t r);
    rsp_t        o;
    int unsigned d;
    o = '0;
    d = 0;
    if (r.reg_index >= REG_SW_RST_REGWEN_LO && r.reg_index <= REG_SW_RST_CTRL_HI)
      d = (r.reg_index - REG_SW_RST_REGWEN_LO) % 8;
    case (r.cmd)
      CMD_READ: begin
        if (r.reg_index >= REG_SW_RST_REGWEN_LO && r.reg_index <= REG_SW_RST_CTRL_HI) begin
          if (d >= NUM_DEV) o.access_error = ERR_BAD;
          else if (r.reg_index <= REG_SW_RST_REGWEN_HI) o.read_data = 32'(dev_wen[d]);
          else o.read_data = 32'(dev_rst_n[d]);
        end else begin
          case (r.reg_index)
            REG_ALERT_TEST:      o.access_error = ERR_WO;
            REG_SWRST_REQ:       o.read_data = 32'(req_code);
            REG_RESET_INFO:      o.read_data = 32'(cause_bits);
            REG_ALERT_REGWEN:    o.read_data = 32'(alert_wen);
            REG_ALERT_INFO_CTRL: o.read_data = 32'(alert_ctrl);
            REG_CPU_REGWEN:      o.read_data = 32'(cpu_wen);
            REG_CPU_INFO_CTRL:   o.read_data = 32'(cpu_ctrl);
            REG_ALERT_INFO_ATTR, REG_ALERT_INFO, REG_CPU_INFO_ATTR, REG_CPU_INFO,
            REG_ERR_CODE: ;
            default:             o.access_error = ERR_BAD;
          endcase
        end
      end
      CMD_WRITE: begin
        if (r.reg_index >= REG_SW_RST_REGWEN_LO && r.reg_index <= REG_SW_RST_CTRL_HI) begin
          if (d >= NUM_DEV) o.access_error = ERR_BAD;
          else if (r.reg_index <= REG_SW_RST_REGWEN_HI) begin
            if (!r.write_data[0]) dev_wen[d] = 1'b0;
          end else if (!dev_wen[d]) o.access_error = ERR_LOCK;
          else dev_rst_n[d] = r.write_data[0];
        end else begin
          case (r.reg_index)
            REG_ALERT_TEST: alert_bits = r.write_data[NUM_ALR-1:0];
            REG_SWRST_REQ: begin
              req_code = r.write_data[3:0];
              if (req_code == MB4_TRUE) begin
                swrst_line = 1'b1;
                if (fatal_cnt != 0) begin
                  fatal_cnt = fatal_cnt - 8'd1;
                  if (fatal_cnt == 0) o.shutdown = 1'b1;
                end
              end
            end
            REG_RESET_INFO:   cause_bits = cause_bits & ~r.write_data[7:0];
            REG_ALERT_REGWEN: alert_wen = alert_wen & r.write_data[0];
            REG_ALERT_INFO_CTRL: begin
              if (!alert_wen) o.access_error = ERR_LOCK;
              else alert_ctrl = r.write_data[7:0] & INFO_CTRL_MASK;
            end
            REG_CPU_REGWEN:   cpu_wen = cpu_wen & r.write_data[0];
            REG_CPU_INFO_CTRL: begin
              if (!cpu_wen) o.access_error = ERR_LOCK;
              else cpu_ctrl = r.write_data[7:0] & INFO_CTRL_MASK;
            end
            REG_ALERT_INFO_ATTR, REG_ALERT_INFO, REG_CPU_INFO_ATTR, REG_CPU_INFO,
            REG_ERR_CODE: o.access_error = ERR_RO;
            default:      o.access_error = ERR_BAD;
          endcase
        end
      end
      CMD_EVENT: begin
        // reason zero is a released line: nothing happens
        if (r.reset_reason != 0) begin
          cause_bits = 8'b1 << r.reset_reason;
          warm_restart();
        end
      end
      default: ;
    endcase
    o.sw_rst_request = swrst_line;
    o.alert_levels   = 2'(alert_bits);
    o.device_reset_n = dev_rst_n;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic rsp_t resp(logic [31:0] data, logic [2:0] err, logic sw,
                                logic [1:0] alr, logic [7:0] dev, logic shut);
    rsp_t o;
    o.read_data      = data;
    o.access_error   = err;
    o.sw_rst_request = sw;
    o.alert_levels   = alr;
    o.device_reset_n = dev;
    o.shutdown       = shut;
    return o;
  endfunction

  function automatic stim_row_t mk(logic [1:0] c, logic [4:0] idx, logic [31:0] data,
                                   logic [2:0] why, bit typed = 1'b0, rsp_t want = '0);
    stim_row_t s;
    s.req.cmd          = c;
    s.req.reg_index    = idx;
    s.req.write_data   = data;
    s.req.reset_reason = why;
    s.typed            = typed;
    s.want             = want;
    return s;
  endfunction

  // Random request: mostly valid register traffic, some bad offsets,
  // occasional reset events. Lock writes lean toward keeping locks open
  // so that guarded writes keep landing.
  function automatic stim_row_t pick_access();
    req_t        r;
    int unsigned p;
    r.write_data   = $urandom();
    r.reset_reason = 3'($urandom_range(7, 0));
    p = $urandom_range(99, 0);
    if (p < 42) r.cmd = CMD_WRITE;
    else if (p < 84) r.cmd = CMD_READ;
    else if (p < 95) r.cmd = CMD_EVENT;
    else r.cmd = CMD_UNUSED;
    if ($urandom_range(99, 0) < 7) r.reg_index = 5'($urandom_range(31, 28));
    else r.reg_index = 5'($urandom_range(27, 0));
    if (r.cmd == CMD_WRITE) begin
      if (r.reg_index == REG_SWRST_REQ && $urandom_range(1, 0) == 1)
        r.write_data[3:0] = MB4_TRUE;
      if ((r.reg_index == REG_ALERT_REGWEN || r.reg_index == REG_CPU_REGWEN ||
           (r.reg_index >= REG_SW_RST_REGWEN_LO && r.reg_index <= REG_SW_RST_REGWEN_HI))
          && $urandom_range(9, 0) < 8)
        r.write_data[0] = 1'b1;
    end
    return mk(r.cmd, r.reg_index, r.write_data, r.reset_reason);
  endfunction

  stim_row_t send_q[$];   // requests waiting to be offered
  rsp_t      want_q[$];   // responses owed by the block, oldest first

  // ---------------------------------------------------------------------
  // Request driver: bursts with random gaps. Prediction happens at the
  // edge where the request is taken.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    rsp_t pred;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = model_access(send_q[0].req);
        want_q.push_back(send_q[0].typed ? send_q[0].want : pred);
        send_q.pop_front();
      end
      // a request not yet taken stays put with its payload
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          in_valid <= 1'b1;
          in_req   <= send_q[0].req;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response side: three stall modes drawn at random; one long hold-off once
  // enough responses are in, so the block backs up into its input.
  // ---------------------------------------------------------------------
  int          checked    = 0;
  int          rx_cycle   = 0;
  int          rx_mode    = 0;
  int          hold_left  = 0;
  bit          held       = 1'b0;
  logic [12:0] stall_pat  = '0;

  always @(posedge clk) begin
    rx_cycle++;
    if (!held && checked >= 600) begin
      hold_left = 300;
      held      = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_cycle % 64 == 0) begin
        rx_mode   = $urandom_range(2, 0);
        stall_pat = 13'($urandom());
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(9, 0) < 6);
        default: begin
          out_ready <= ~stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[12:1]};
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Response checker
  // ---------------------------------------------------------------------
  int faults = 0;

  task automatic report(string what, rsp_t exp, rsp_t got);
    if (faults < 10) begin
      $write("%s: exp data=%h err=%0d sw=%b alr=%b dev=%h shut=%b",
             what, exp.read_data, exp.access_error, exp.sw_rst_request,
             exp.alert_levels, exp.device_reset_n, exp.shutdown);
      $display(" | got data=%h err=%0d sw=%b alr=%b dev=%h shut=%b",
               got.read_data, got.access_error, got.sw_rst_request,
               got.alert_levels, got.device_reset_n, got.shutdown);
    end
    faults++;
  endtask

  always @(posedge clk) begin
    rsp_t exp;
    if (!rst && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        report("response with nothing owed", '0, out_rsp);
      end else begin
        exp = want_q.pop_front();
        if (out_rsp.read_data !== exp.read_data ||
            out_rsp.access_error !== exp.access_error ||
            out_rsp.sw_rst_request !== exp.sw_rst_request ||
            out_rsp.alert_levels !== exp.alert_levels ||
            out_rsp.device_reset_n !== exp.device_reset_n ||
            out_rsp.shutdown !== exp.shutdown)
          report("mismatch", exp, out_rsp);
      end
      checked <= checked + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------
  // block is idle once nothing waits to go in and nothing is owed
  task automatic drain();
    while (send_q.size() != 0 || want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // fatal limit write, only while idle; also reloads the countdown
  task automatic load_fatal_limit(logic [7:0] v);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    fatal_lim = v;
    fatal_cnt = v;
  endtask

  initial begin
    stim_row_t  dir_tab[$];
    logic [7:0] limits[$];
    power_on();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: limit of two so the countdown hits zero inside the table
    load_fatal_limit(8'd2);
    dir_tab = '{
      // power-on values
      mk(CMD_READ, REG_RESET_INFO, '0, '0, 1'b1,
         resp(32'(CAUSE_POR), ERR_OK, 1'b0, 2'b00, 8'hff, 1'b0)),
      mk(CMD_READ, REG_SWRST_REQ, '0, '0, 1'b1,
         resp(32'(MB4_FALSE), ERR_OK, 1'b0, 2'b00, 8'hff, 1'b0)),
      // access errors
      mk(CMD_READ, REG_ALERT_TEST, '0, '0, 1'b1,
         resp('0, ERR_WO, 1'b0, 2'b00, 8'hff, 1'b0)),
      mk(CMD_READ, 5'd31, '0, '0, 1'b1,
         resp('0, ERR_BAD, 1'b0, 2'b00, 8'hff, 1'b0)),
      mk(CMD_WRITE, 5'd28, 32'hffff_ffff, 3'd7, 1'b1,
         resp('0, ERR_BAD, 1'b0, 2'b00, 8'hff, 1'b0)),
      mk(CMD_WRITE, REG_ALERT_INFO_ATTR, 32'hffff_ffff, '0, 1'b1,
         resp('0, ERR_RO, 1'b0, 2'b00, 8'hff, 1'b0)),
      // alert test bits and info control masking
      mk(CMD_WRITE, REG_ALERT_TEST, 32'hffff_ffff, '0, 1'b1,
         resp('0, ERR_OK, 1'b0, 2'b11, 8'hff, 1'b0)),
      mk(CMD_WRITE, REG_ALERT_INFO_CTRL, 32'hffff_ffff, '0, 1'b1,
         resp('0, ERR_OK, 1'b0, 2'b11, 8'hff, 1'b0)),
      mk(CMD_READ, REG_ALERT_INFO_CTRL, '0, '0, 1'b1,
         resp(32'(INFO_CTRL_MASK), ERR_OK, 1'b0, 2'b11, 8'hff, 1'b0)),
      // close the alert lock, then a guarded write is refused
      mk(CMD_WRITE, REG_ALERT_REGWEN, '0, '0),
      mk(CMD_WRITE, REG_ALERT_INFO_CTRL, '0, '0, 1'b1,
         resp('0, ERR_LOCK, 1'b0, 2'b11, 8'hff, 1'b0)),
      mk(CMD_WRITE, REG_CPU_INFO_CTRL, 32'h0000_005a, '0),
      mk(CMD_WRITE, REG_CPU_REGWEN, 32'hffff_fffe, '0),
      mk(CMD_WRITE, REG_CPU_INFO_CTRL, 32'hffff_ffff, '0, 1'b1,
         resp('0, ERR_LOCK, 1'b0, 2'b11, 8'hff, 1'b0)),
      // per-device controls and their locks
      mk(CMD_WRITE, REG_SW_RST_CTRL_LO, '0, '0),
      mk(CMD_WRITE, REG_SW_RST_REGWEN_HI, '0, '0),
      mk(CMD_WRITE, REG_SW_RST_CTRL_HI, '0, '0),
      // other code stored only; true code twice reaches zero; then no pulse
      mk(CMD_WRITE, REG_SWRST_REQ, 32'h0000_0003, '0),
      mk(CMD_WRITE, REG_SWRST_REQ, 32'(MB4_TRUE), '0),
      mk(CMD_WRITE, REG_SWRST_REQ, 32'hffff_fff6, '0),
      mk(CMD_WRITE, REG_SWRST_REQ, 32'(MB4_TRUE), '0),
      // unused command, released reset line, then a real reset request
      mk(CMD_UNUSED, REG_RESET_INFO, 32'hffff_ffff, 3'd7),
      mk(CMD_EVENT, REG_RESET_INFO, '0, 3'd0),
      mk(CMD_EVENT, 5'd31, 32'hffff_ffff, 3'd7),
      mk(CMD_WRITE, REG_RESET_INFO, 32'hffff_ffff, '0),
      mk(CMD_READ, REG_RESET_INFO, '0, '0)
    };
    foreach (dir_tab[i]) send_q.push_back(dir_tab[i]);
    drain();

    // Random phases, each under its own fatal limit
    limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(6, 2)), 8'd3};
    foreach (limits[p]) begin
      load_fatal_limit(limits[p]);
      repeat (320) send_q.push_back(pick_access());
      drain();
    end

    repeat (8) @(posedge clk);
    faults += want_q.size();
    if (faults == 0)
      $display("reset_manager_register_bank_tb: done, clean");
    else
      $display("reset_manager_register_bank_tb: done, errors");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("reset_manager_register_bank_tb: done, errors");
    $finish;
  end

endmodule
